@@ sv/ashg_pkg.sv @@
`default_nettype none
package ashg_pkg;

    // Scan geometry
    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SAMPLE_BITS  = 10;
    localparam int THR_W        = 10;
    localparam int SETTLE_W     = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THR    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE     = 2'd2;

    localparam logic [THR_W-1:0]    LOW_THR_RESET  = 10'd200;
    localparam logic [THR_W-1:0]    HIGH_THR_RESET = 10'd1000;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 8'd10;

    // Stream widths
    localparam int IN_BITS  = 1 + SAMPLE_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + 1 + CH_W + 1 + CH_W + SAMPLE_BITS + 1 + 1 + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [THR_W-1:0]    low_thr;
        logic [THR_W-1:0]    high_thr;
        logic [SETTLE_W-1:0] settle;
    } t_cfg;

    // Field order from the top bit down; packs lowest-first into tdata
    typedef struct packed {
        logic                   falling_edge;
        logic                   rising_edge;
        logic                   level_high;
        logic [SAMPLE_BITS-1:0] store_value;
        logic [CH_W-1:0]        store_channel;
        logic                   store_valid;
        logic [CH_W-1:0]        select_channel;
        logic                   select_valid;
        logic                   start_conversion;
    } t_result;

endpackage
`default_nettype wire

@@ sv/ashg_cfg.sv @@
`default_nettype none
module ashg_cfg
    import ashg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr  <= LOW_THR_RESET;
            r_cfg.high_thr <= HIGH_THR_RESET;
            r_cfg.settle   <= SETTLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LOW_THR:  r_cfg.low_thr  <= i_cfg_wdata[THR_W-1:0];
                REG_HIGH_THR: r_cfg.high_thr <= i_cfg_wdata[THR_W-1:0];
                REG_SETTLE:   r_cfg.settle   <= i_cfg_wdata[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ sv/ashg_core.sv @@
`default_nettype none
module ashg_core
    import ashg_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_busy,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire t_cfg                   i_cfg,
    output t_result                     o_res
);

    logic                    r_started;
    logic [CH_W-1:0]         r_chan;
    logic [SETTLE_W-1:0]     r_settle;
    logic [NUM_CHANNELS-1:0] r_level;

    logic                    n_started;
    logic [CH_W-1:0]         n_chan;
    logic [SETTLE_W-1:0]     n_settle;
    logic [NUM_CHANNELS-1:0] n_level;
    logic                    old_lvl;
    logic                    now_lvl;
    t_result                 res;

    // Settle countdown, scan start, hysteresis and channel advance for one tick
    always_comb begin
        n_started = r_started;
        n_chan    = r_chan;
        n_settle  = r_settle;
        n_level   = r_level;
        old_lvl   = r_level[r_chan];
        now_lvl   = old_lvl;
        res       = '0;
        if (r_settle != '0) begin
            n_settle = r_settle - 1'b1;
            res.start_conversion = (r_settle == SETTLE_W'(1));
        end else if (!i_busy) begin
            if (!r_started) begin
                n_started = 1'b1;
                n_chan    = '0;
            end else begin
                if (old_lvl) begin
                    if (i_sample <= i_cfg.low_thr) begin
                        now_lvl          = 1'b0;
                        res.falling_edge = 1'b1;
                    end
                end else if (i_sample >= i_cfg.high_thr) begin
                    now_lvl         = 1'b1;
                    res.rising_edge = 1'b1;
                end
                n_level[r_chan]   = now_lvl;
                res.store_valid   = 1'b1;
                res.store_channel = r_chan;
                res.store_value   = i_sample;
                res.level_high    = now_lvl;
                n_chan = (r_chan == CH_W'(NUM_CHANNELS - 1)) ? '0 : r_chan + 1'b1;
            end
            res.select_valid   = 1'b1;
            res.select_channel = n_chan;
            n_settle = (i_cfg.settle == '0) ? SETTLE_W'(1) : i_cfg.settle;
        end
    end

    // Advance scan state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_chan    <= '0;
            r_settle  <= '0;
            r_level   <= '0;
        end else if (i_step) begin
            r_started <= n_started;
            r_chan    <= n_chan;
            r_settle  <= n_settle;
            r_level   <= n_level;
        end
    end

    assign o_res = res;

endmodule
`default_nettype wire

@@ sv/adc_scan_hysteresis_gate_top.sv @@
`default_nettype none
// Each input transfer's result is captured in the output register when it is accepted.
// Throughput: one tick per cycle; the input stays ready while the output register
// is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous): scan not started, channel 0, no settle count,
// all levels low, thresholds 200/1000, settle count 10, output register empty.
module adc_scan_hysteresis_gate_top
    import ashg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: [0] converter_busy, [10:1] sample
    input  wire logic [IN_W-1:0]       s_axis_tdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: [0] start_conversion, [1] select_valid, [3:2] select_channel,
    // [4] store_valid, [6:5] store_channel, [16:7] store_value,
    // [17] level_high, [18] rising_edge, [19] falling_edge
    output logic [OUT_W-1:0]           m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg             cfg;
    t_result          res;
    logic             step;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    ashg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    // Take a tick whenever the result register is free or drains this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    ashg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_busy  (s_axis_tdata[0]),
        .i_sample(s_axis_tdata[SAMPLE_BITS:1]),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Hold the result until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= OUT_W'(res);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

@@ test/adc_scan_hysteresis_gate_top_tb.sv @@
`default_nettype none
module adc_scan_hysteresis_gate_top_tb;
    import ashg_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_PRINTED = 40;

    // One scheduler tick as it travels on the input stream
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   busy;
    } t_tick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire logic             s_axis_tready;
    wire logic [OUT_W-1:0] m_axis_tdata;
    wire logic             m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    adc_scan_hysteresis_gate_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Scanner state mirrored on the testbench side
    logic [THR_W-1:0]        cfg_low = LOW_THR_RESET;
    logic [THR_W-1:0]        cfg_high = HIGH_THR_RESET;
    logic [SETTLE_W-1:0]     cfg_settle = SETTLE_RESET;
    logic                    scan_running = 1'b0;
    logic [CH_W-1:0]         scan_chan = '0;
    logic [SETTLE_W-1:0]     settle_left = '0;
    logic [NUM_CHANNELS-1:0] chan_high = '0;

    t_tick   tick_items[$];
    t_result scan_results[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      ticks_queued = 0;

    // Advance the scanner by one tick and return the result it emits
    function automatic t_result scan_tick(input t_tick tk);
        t_result r;
        logic [CH_W-1:0] ch;
        r = '0;
        if (settle_left != 0) begin
            settle_left = settle_left - 1'b1;
            if (settle_left == 0)
                r.start_conversion = 1'b1;
        end else if (!tk.busy) begin
            if (!scan_running) begin
                scan_running = 1'b1;
                scan_chan = '0;
            end else begin
                ch = scan_chan;
                if (chan_high[ch]) begin
                    if (tk.sample <= cfg_low) begin
                        chan_high[ch] = 1'b0;
                        r.falling_edge = 1'b1;
                    end
                end else if (tk.sample >= cfg_high) begin
                    chan_high[ch] = 1'b1;
                    r.rising_edge = 1'b1;
                end
                r.store_valid = 1'b1;
                r.store_channel = ch;
                r.store_value = tk.sample;
                r.level_high = chan_high[ch];
                scan_chan = (ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch + 1'b1;
            end
            r.select_valid = 1'b1;
            r.select_channel = scan_chan;
            settle_left = (cfg_settle == 0) ? SETTLE_W'(1) : cfg_settle;
        end
        return r;
    endfunction

    // Random tick, samples clustered around both thresholds and the rails
    function automatic t_tick random_tick();
        t_tick tk;
        int v;
        int offs;
        offs = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 7))
            0, 1:    v = int'(cfg_low) + offs;
            2, 3:    v = int'(cfg_high) + offs;
            4:       v = ($urandom_range(0, 1) == 1) ? 1023 : 0;
            default: v = int'($urandom_range(0, 1023));
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        tk.busy = ($urandom_range(0, 9) < 3);
        tk.sample = v[SAMPLE_BITS-1:0];
        return tk;
    endfunction

    task automatic add_tick(input logic busy, input int sample);
        t_tick tk;
        tk.busy = busy;
        tk.sample = sample[SAMPLE_BITS-1:0];
        tick_items.push_back(tk);
        ticks_queued++;
    endtask

    task automatic add_random_ticks(input int n);
        repeat (n) begin
            tick_items.push_back(random_tick());
            ticks_queued++;
        end
    endtask

    // Hold until every queued tick has come back as a result
    task automatic drain_scanner();
        while (results_seen != ticks_queued)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_LOW_THR:  cfg_low = val[THR_W-1:0];
            REG_HIGH_THR: cfg_high = val[THR_W-1:0];
            REG_SETTLE:   cfg_settle = val[SETTLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_scan(input int low, input int high, input int settle);
        cfg_write(REG_LOW_THR, CFG_DATA_W'(low));
        cfg_write(REG_HIGH_THR, CFG_DATA_W'(high));
        cfg_write(REG_SETTLE, CFG_DATA_W'(settle));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of random length separated by random gaps
    t_tick offered;
    int    burst_left;
    int    gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                scan_results.push_back(scan_tick(offered));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_items.size() != 0) begin
                    offered = tick_items.pop_front();
                    s_axis_tdata  <= IN_W'(offered);
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: pacing pattern stepped by the rx_cycle counter, plus one long hold-off
    logic [15:0] rx_cycle;
    int          hold_left;
    logic        hold_taken;

    always @(posedge i_clk) begin : rx_pace
        logic rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cycle      <= '0;
            hold_left     <= 0;
            hold_taken    <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            case (rx_cycle[8:6])
                3'd0, 3'd1: rdy = 1'b1;
                3'd2:       rdy = ($urandom_range(0, 1) == 1);
                3'd3:       rdy = (rx_cycle[1:0] != 2'd0);
                3'd4:       rdy = ($urandom_range(0, 4) != 0);
                3'd5:       rdy = rx_cycle[0];
                default:    rdy = ($urandom_range(0, 3) != 0);
            endcase
            if (!hold_taken && results_seen >= 400) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                rdy = 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                rdy = 1'b0;
            end
            m_axis_tready <= rdy;
        end
    end

    // Compare each output transfer with the oldest expected result
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got = t_result'(m_axis_tdata[OUT_BITS-1:0]);
            if (scan_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", int'(m_axis_tdata), 0);
            end else begin
                want = scan_results.pop_front();
                if (got.start_conversion != want.start_conversion)
                    report_mismatch("start_conversion", got.start_conversion,
                                    want.start_conversion);
                if (got.select_valid != want.select_valid)
                    report_mismatch("select_valid", got.select_valid, want.select_valid);
                if (got.select_channel != want.select_channel)
                    report_mismatch("select_channel", got.select_channel,
                                    want.select_channel);
                if (got.store_valid != want.store_valid)
                    report_mismatch("store_valid", got.store_valid, want.store_valid);
                if (got.store_channel != want.store_channel)
                    report_mismatch("store_channel", got.store_channel, want.store_channel);
                if (got.store_value != want.store_value)
                    report_mismatch("store_value", got.store_value, want.store_value);
                if (got.level_high != want.level_high)
                    report_mismatch("level_high", got.level_high, want.level_high);
                if (got.rising_edge != want.rising_edge)
                    report_mismatch("rising_edge", got.rising_edge, want.rising_edge);
                if (got.falling_edge != want.falling_edge)
                    report_mismatch("falling_edge", got.falling_edge, want.falling_edge);
                if (m_axis_tdata[OUT_W-1:OUT_BITS] != '0)
                    report_mismatch("tdata padding", int'(m_axis_tdata[OUT_W-1:OUT_BITS]), 0);
            end
        end
    end

    // End the run if nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("adc_scan_hysteresis_gate_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus phases
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: scan start, ignored inputs while settling, busy tick,
        // then a rise exactly at the high threshold
        add_tick(1'b0, 5);
        for (int k = 0; k < 10; k++)
            add_tick(k[0], (k % 2 == 0) ? 1023 : 0);
        add_tick(1'b1, 1023);
        add_tick(1'b0, 1000);
        drain_scanner();

        // Zero settle count acts as one; walk the thresholds at their boundaries
        cfg_write(REG_SETTLE, '0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        add_tick(1'b1, 1023); add_tick(1'b0, 999);
        add_tick(1'b1, 1023); add_tick(1'b0, 1023);
        add_tick(1'b1, 1023); add_tick(1'b0, 0);
        add_tick(1'b1, 1023); add_tick(1'b0, 201);
        add_tick(1'b1, 1023); add_tick(1'b0, 1000);
        add_tick(1'b1, 1023); add_tick(1'b0, 200);
        drain_scanner();

        // Widest window, shortest settle
        set_scan(0, 1023, 1);
        add_random_ticks(250);
        drain_scanner();

        // Ignored register index, then fully crossed thresholds
        cfg_write(REG_UNMAPPED, 10'h155);
        set_scan(1023, 0, 2);
        add_random_ticks(250);
        drain_scanner();

        // Longest settle, upper write bits dropped
        set_scan(600, 400, 10'h3FF);
        add_random_ticks(280);
        drain_scanner();

        set_scan(300, 700, 3);
        add_random_ticks(300);
        drain_scanner();

        begin
            int lo;
            lo = $urandom_range(0, 1023);
            set_scan(lo, $urandom_range(lo, 1023), $urandom_range(1, 6));
        end
        add_random_ticks(300);
        drain_scanner();

        set_scan(200, 800, 0);
        add_random_ticks(370);
        drain_scanner();

        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("adc_scan_hysteresis_gate_top regression: pass");
        else
            $display("adc_scan_hysteresis_gate_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
